>>> src/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the reset is asserted.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/trlc_pkg.sv
`timescale 1ns / 1ps

package trlc_pkg;

	localparam int NUM_LETTERS = 26;
	localparam int LETTER_W    = 5;

	typedef logic [LETTER_W-1:0] letter_t;
	typedef logic [1:0]          func_t;
	typedef logic [1:0]          sel_t;
	typedef letter_t             tab_t [NUM_LETTERS];

	// Operation codes.
	localparam func_t FUNC_ENC = 2'd0;
	localparam func_t FUNC_SET = 2'd1;
	localparam func_t FUNC_CLR = 2'd2;

	// Rotor select codes.
	localparam sel_t SEL_FAST = 2'd0;
	localparam sel_t SEL_MID  = 2'd1;
	localparam sel_t SEL_SLOW = 2'd2;

	localparam letter_t LAST_LETTER = letter_t'(NUM_LETTERS - 1);
	localparam letter_t FAST_NOTCH  = 5'd22;
	localparam letter_t MID_NOTCH   = 5'd4;

	// Rotor positions packed as one memory word.
	typedef struct packed {
		letter_t slow;
		letter_t mid;
		letter_t fast;
	} rotors_t;

	localparam int STATE_W     = $bits(rotors_t);
	localparam int STATE_DEPTH = 1;
	localparam int STATE_AW    = 1;
	localparam logic [STATE_AW-1:0] STATE_ADDR = '0;

	localparam tab_t WHEEL_FAST = '{
		5'd3, 5'd12, 5'd19, 5'd22, 5'd18, 5'd8, 5'd11, 5'd17, 5'd20, 5'd24, 5'd16, 5'd13, 5'd10,
		5'd5, 5'd4, 5'd9, 5'd2, 5'd0, 5'd25, 5'd1, 5'd15, 5'd6, 5'd23, 5'd14, 5'd7, 5'd21};
	localparam tab_t WHEEL_MID = '{
		5'd7, 5'd16, 5'd25, 5'd6, 5'd15, 5'd9, 5'd19, 5'd12, 5'd14, 5'd1, 5'd11, 5'd13, 5'd2,
		5'd8, 5'd5, 5'd3, 5'd24, 5'd0, 5'd22, 5'd21, 5'd4, 5'd20, 5'd18, 5'd17, 5'd10, 5'd23};
	localparam tab_t WHEEL_SLOW = '{
		5'd20, 5'd16, 5'd13, 5'd19, 5'd11, 5'd18, 5'd25, 5'd5, 5'd12, 5'd17, 5'd4, 5'd7, 5'd3,
		5'd15, 5'd23, 5'd10, 5'd8, 5'd1, 5'd21, 5'd24, 5'd6, 5'd9, 5'd2, 5'd22, 5'd14, 5'd0};
	localparam tab_t MIRROR = '{
		5'd6, 5'd2, 5'd1, 5'd16, 5'd13, 5'd8, 5'd0, 5'd17, 5'd5, 5'd19, 5'd15, 5'd22, 5'd25,
		5'd4, 5'd23, 5'd10, 5'd3, 5'd7, 5'd20, 5'd9, 5'd18, 5'd24, 5'd11, 5'd14, 5'd21, 5'd12};
	localparam tab_t PLUGS = '{
		5'd2, 5'd1, 5'd0, 5'd3, 5'd4, 5'd5, 5'd6, 5'd7, 5'd8, 5'd9, 5'd10, 5'd11, 5'd15,
		5'd13, 5'd14, 5'd12, 5'd16, 5'd17, 5'd18, 5'd19, 5'd20, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25};

	// Inverse wiring of a rotor, built at elaboration.
	function automatic tab_t invert(tab_t t);
		tab_t r;
		for (int i = 0; i < NUM_LETTERS; i++) begin
			r[t[i]] = letter_t'(i);
		end
		return r;
	endfunction

	localparam tab_t INV_FAST = invert(WHEEL_FAST);
	localparam tab_t INV_MID  = invert(WHEEL_MID);
	localparam tab_t INV_SLOW = invert(WHEEL_SLOW);

	// Folds a 5-bit value into 0..25.
	function automatic letter_t fold26(letter_t x);
		return (x >= letter_t'(NUM_LETTERS)) ? letter_t'(x - letter_t'(NUM_LETTERS)) : x;
	endfunction

	function automatic letter_t add26(letter_t a, letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + {1'b0, b};
		return (s >= (LETTER_W+1)'(NUM_LETTERS)) ?
			letter_t'(s - (LETTER_W+1)'(NUM_LETTERS)) : s[LETTER_W-1:0];
	endfunction

	function automatic letter_t sub26(letter_t a, letter_t b);
		logic [LETTER_W:0] s;
		s = {1'b0, a} + (LETTER_W+1)'(NUM_LETTERS) - {1'b0, b};
		return (s >= (LETTER_W+1)'(NUM_LETTERS)) ?
			letter_t'(s - (LETTER_W+1)'(NUM_LETTERS)) : s[LETTER_W-1:0];
	endfunction

	function automatic letter_t inc26(letter_t a);
		return (a == LAST_LETTER) ? '0 : letter_t'(a + 5'd1);
	endfunction

endpackage

>>> src/three_rotor_letter_cipher.sv
`timescale 1ns / 1ps

// Channel | Handshake           | Payload
// input   | in_valid, in_stall  | func, letter, rotor_select, new_position
// output  | out_valid, out_stall| out_letter, fast_pos_now, mid_pos_now, slow_pos_now
//
// One word is accepted per cycle while in_stall is low, and each yields one
// result word out of the output register. The rate is set by the state memory's
// rotor state word read-modify-write, which forwarding keeps at one per cycle.
// Reset clears all valid flags. The state memory is not cleared; a flag marks
// that it was never written, and until then it reads as all positions zero.
// A stall on the output backs up the pipeline stage by stage, and in_stall rises
// only when the first stage is full and cannot move.

module three_rotor_letter_cipher (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  trlc_pkg::func_t  func,
	input  trlc_pkg::letter_t letter,
	input  trlc_pkg::sel_t   rotor_select,
	input  trlc_pkg::letter_t new_position,
	output logic             out_valid,
	input  logic             out_stall,
	output trlc_pkg::letter_t out_letter,
	output trlc_pkg::letter_t fast_pos_now,
	output trlc_pkg::letter_t mid_pos_now,
	output trlc_pkg::letter_t slow_pos_now
);

	import trlc_pkg::*;

	// Stage valids and the flags that tell whether a stage can take a word.
	logic v_s1_q, v_s2_q, v_s3_q, v_s4_q, out_vld_q;
	logic free_s1, free_s2, free_s3, free_s4, free_out;
	logic in_acc;

	// Stage 1: the accepted word while the state memory is read.
	func_t   func_s1;
	letter_t let_s1;
	sel_t    sel_s1;
	letter_t npos_s1;
	logic    fwd_s1;
	logic    seen_s1;

	// State memory port and forwarding.
	logic [STATE_W-1:0] ram_rdata;
	logic               ram_we;
	rotors_t            wr_q;
	logic               mem_ok_q;
	rotors_t            cur_s1, stepped_s1, nxt_s1;

	// Later stages carry the old positions for the cipher path and the new
	// positions for the result.
	logic    enc_s2, enc_s3, enc_s4;
	rotors_t pre_s2, pre_s3, pre_s4;
	rotors_t post_s2, post_s3, post_s4;
	letter_t let_s2, sig_s3, sig_s4;
	letter_t sig_c2, sig_c3, sig_c4;

	rotors_t out_pos_q;
	letter_t out_letter_q;

	// The free flags ripple back from the output register.
	assign free_out = !out_vld_q || !out_stall;
	assign free_s4  = !v_s4_q || free_out;
	assign free_s3  = !v_s3_q || free_s4;
	assign free_s2  = !v_s2_q || free_s3;
	assign free_s1  = !v_s1_q || free_s2;
	assign in_stall = !free_s1;
	assign in_acc   = in_valid && free_s1;

	// The word in stage 1 writes back its new positions as it moves on.
	assign ram_we = v_s1_q && free_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1_q    <= 1'b0;
			v_s2_q    <= 1'b0;
			v_s3_q    <= 1'b0;
			v_s4_q    <= 1'b0;
			out_vld_q <= 1'b0;
			mem_ok_q  <= 1'b0;
		end else begin
			if (free_s1) begin
				v_s1_q <= in_valid;
			end
			if (free_s2) begin
				v_s2_q <= v_s1_q;
			end
			if (free_s3) begin
				v_s3_q <= v_s2_q;
			end
			if (free_s4) begin
				v_s4_q <= v_s3_q;
			end
			if (free_out) begin
				out_vld_q <= v_s4_q;
			end
			if (ram_we) begin
				mem_ok_q <= 1'b1;
			end
		end
	end

	trlc_ram #(
		.WIDTH(STATE_W),
		.DEPTH(STATE_DEPTH),
		.AW   (STATE_AW)
	) u_state_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(STATE_ADDR),
		.wdata(nxt_s1),
		.re   (in_acc),
		.raddr(STATE_ADDR),
		.rdata(ram_rdata)
	);

	// Stage 1 capture. Out-of-range letters and positions are folded here.
	// When the previous word writes the memory at the same edge as this read,
	// the read sees old data, so the written value is taken from wr_q instead.
	always_ff @(posedge clk) begin
		if (free_s1) begin
			func_s1 <= func;
			let_s1  <= fold26(letter);
			sel_s1  <= rotor_select;
			npos_s1 <= fold26(new_position);
			fwd_s1  <= ram_we;
			seen_s1 <= mem_ok_q;
		end
		if (ram_we) begin
			wr_q <= nxt_s1;
		end
	end

	always_comb begin
		if (fwd_s1) begin
			cur_s1 = wr_q;
		end else if (seen_s1) begin
			cur_s1 = rotors_t'(ram_rdata);
		end else begin
			cur_s1 = '0;
		end
	end

	// Odometer stepping: the middle rotor moves when the fast one lands on its
	// notch, and the slow rotor when the middle one lands on its notch.
	always_comb begin
		stepped_s1      = cur_s1;
		stepped_s1.fast = inc26(cur_s1.fast);
		if (stepped_s1.fast == FAST_NOTCH) begin
			stepped_s1.mid = inc26(cur_s1.mid);
			if (stepped_s1.mid == MID_NOTCH) begin
				stepped_s1.slow = inc26(cur_s1.slow);
			end
		end
	end

	always_comb begin
		nxt_s1 = cur_s1;
		unique case (func_s1)
			FUNC_ENC: begin
				nxt_s1 = stepped_s1;
			end
			FUNC_SET: begin
				unique case (sel_s1)
					SEL_FAST: nxt_s1.fast = npos_s1;
					SEL_MID:  nxt_s1.mid  = npos_s1;
					SEL_SLOW: nxt_s1.slow = npos_s1;
					default:  nxt_s1      = cur_s1;
				endcase
			end
			FUNC_CLR: begin
				nxt_s1 = '0;
			end
			default: begin
				nxt_s1 = cur_s1;
			end
		endcase
	end

	// Stage 2: plugboard, fast rotor and middle rotor on the way in.
	always_comb begin
		sig_c2 = PLUGS[let_s2];
		sig_c2 = WHEEL_FAST[add26(sig_c2, pre_s2.fast)];
		sig_c2 = WHEEL_MID[add26(sig_c2, pre_s2.mid)];
	end

	// Stage 3: slow rotor, reflector, and the slow rotor on the way back.
	always_comb begin
		sig_c3 = WHEEL_SLOW[add26(sig_s3, pre_s3.slow)];
		sig_c3 = MIRROR[sig_c3];
		sig_c3 = sub26(INV_SLOW[sig_c3], pre_s3.slow);
	end

	// Stage 4: middle and fast rotors backward, then the plugboard again.
	// Only an encryption shows a letter; the other operations show zero.
	always_comb begin
		sig_c4 = sub26(INV_MID[sig_s4], pre_s4.mid);
		sig_c4 = sub26(INV_FAST[sig_c4], pre_s4.fast);
		sig_c4 = enc_s4 ? PLUGS[sig_c4] : '0;
	end

	always_ff @(posedge clk) begin
		if (free_s2) begin
			enc_s2  <= (func_s1 == FUNC_ENC);
			pre_s2  <= cur_s1;
			post_s2 <= nxt_s1;
			let_s2  <= let_s1;
		end
		if (free_s3) begin
			enc_s3  <= enc_s2;
			pre_s3  <= pre_s2;
			post_s3 <= post_s2;
			sig_s3  <= sig_c2;
		end
		if (free_s4) begin
			enc_s4  <= enc_s3;
			pre_s4  <= pre_s3;
			post_s4 <= post_s3;
			sig_s4  <= sig_c3;
		end
		if (free_out) begin
			out_letter_q <= sig_c4;
			out_pos_q    <= post_s4;
		end
	end

	assign out_valid    = out_vld_q;
	assign out_letter   = out_letter_q;
	assign fast_pos_now = out_pos_q.fast;
	assign mid_pos_now  = out_pos_q.mid;
	assign slow_pos_now = out_pos_q.slow;

endmodule

>>> src/trlc_ram.sv
`timescale 1ns / 1ps

module trlc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Read returns the contents from before a write at the same edge.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> src/trlc_checker.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module trlc_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              out_valid,
	input logic              out_stall,
	input trlc_pkg::letter_t out_letter,
	input trlc_pkg::letter_t fast_pos_now,
	input trlc_pkg::letter_t mid_pos_now,
	input trlc_pkg::letter_t slow_pos_now
);

	import trlc_pkg::*;

	logic [4*LETTER_W-1:0] out_word;
	logic                  out_in_range;

	assign out_word     = {out_letter, fast_pos_now, mid_pos_now, slow_pos_now};
	assign out_in_range = (out_letter <= LAST_LETTER) && (fast_pos_now <= LAST_LETTER) &&
		(mid_pos_now <= LAST_LETTER) && (slow_pos_now <= LAST_LETTER);

	// A result word that is stalled stays offered.
	`CHK_ASSERT(a_out_hold, clk, arst_n, out_valid && out_stall |=> out_valid, "result word dropped while stalled")

	// A stalled result word does not change.
	`CHK_ASSERT(a_out_stable, clk, arst_n, out_valid && out_stall |=> $stable(out_word), "stalled result word changed")

	// Every shown letter and position lies in the alphabet.
	`CHK_ASSERT(a_out_range, clk, arst_n, out_valid |-> out_in_range, "result field out of range")

	// No result word comes out right after reset is released.
	`CHK_ASSERT(a_reset_empty, clk, arst_n, $rose(arst_n) |-> !out_valid, "result word present after reset")

endmodule

bind three_rotor_letter_cipher trlc_checker u_trlc_checker (.*);
